@@ rtl/core/kvsp_pkg.sv @@
package kvsp_pkg;

  // default size of the lexer buffer in bytes
  localparam int unsigned BufferBytesDflt = 32'd4096;

  localparam int unsigned PosW  = 12;
  localparam int unsigned LineW = 16;

  // bytes removed from a quoted string, one quote at each end
  localparam logic [PosW-1:0] QuoteTrim = 12'd2;

  typedef enum logic [3:0] {
    TOK_ILLEGAL = 4'd0,
    TOK_NEWLINE = 4'd1,
    TOK_RETURN  = 4'd2,
    TOK_SPACE   = 4'd3,
    TOK_COMMENT = 4'd4,
    TOK_ASSIGN  = 4'd5,
    TOK_QUOTED  = 4'd6,
    TOK_RAW     = 4'd7,
    TOK_END     = 4'd8
  } kvsp_tok_e;

  typedef enum logic [2:0] {
    ERR_NONE     = 3'd0,
    ERR_NEWLINE  = 3'd1,
    ERR_COMMENT  = 3'd2,
    ERR_OPERATOR = 3'd3,
    ERR_STRING   = 3'd4,
    ERR_ILLEGAL  = 3'd5
  } kvsp_err_e;

  typedef enum logic [4:0] {
    PH_KEY    = 5'b00001,
    PH_ASSIGN = 5'b00010,
    PH_VALUE  = 5'b00100,
    PH_TRAIL  = 5'b01000,
    PH_END    = 5'b10000
  } kvsp_phase_e;

  typedef struct packed {
    logic [3:0]      token_kind;
    logic [PosW-1:0] token_position;
    logic [PosW-1:0] token_length;
    logic            comment_hits_end;
  } kvsp_tok_t;

  typedef struct packed {
    logic             statement_done;
    logic             pair_ready;
    logic [PosW-1:0]  key_start;
    logic [PosW-1:0]  key_size;
    logic [PosW-1:0]  value_start;
    logic [PosW-1:0]  value_size;
    logic [2:0]       error_code;
    logic             warning_code;
    logic [PosW-1:0]  error_column;
    logic [PosW-1:0]  warning_column;
    logic [LineW-1:0] line_number;
    logic             end_of_input;
  } kvsp_res_t;

endpackage

@@ rtl/core/kvsp_if.sv @@
interface kvsp_tok_if;
  import kvsp_pkg::*;

  logic      valid;
  logic      ready;
  kvsp_tok_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface kvsp_res_if;
  import kvsp_pkg::*;

  logic      valid;
  logic      ready;
  kvsp_res_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

@@ rtl/core/key_value_statement_parser.sv @@
// key = value statement parser, fed one lexer token per transaction
//
// token_i carries one token (type, buffer position, length and, for
// comments, whether skipping the line reached end of input). result_o
// returns exactly one result per token: whether the token closed a
// statement, whether a key/value pair is ready, the captured spans, the
// line count and the sticky error and warning status.
// a token accepted on token_i is held in the token register, evaluated
// against the parser state, and its result is written to the result
// register, from which it is offered on result_o.
// throughput: one token per cycle; the token register and the result
// register each take a new transaction whenever the stage after them
// frees up in the same cycle.
// reset (rst_ni low) returns the parser to waiting for a key and clears
// spans, line count, error and warning. after an error or an end of
// input the parser halts: tokens are still taken and answered, with the
// held status and no statement closed, until reset.
// a stall on result_o holds the result register, then the token
// register, and only then drops token_i.ready; nothing is lost.
module key_value_statement_parser #(
  parameter int unsigned BufferBytes = kvsp_pkg::BufferBytesDflt
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  kvsp_tok_if.sink   token_i,
  kvsp_res_if.source result_o
);
  import kvsp_pkg::*;

  // token register in front of the parser logic
  kvsp_tok_t tok_q;
  logic      tok_valid_q, tok_valid_d;

  // result register on the output side
  kvsp_res_t res_q;
  kvsp_res_t res_next;
  logic      res_valid_q, res_valid_d;

  logic      advance;
  logic      tok_take;

  // the registered token moves on when the result register is free or drains now
  assign advance  = tok_valid_q && (!res_valid_q || result_o.ready);
  assign tok_take = token_i.valid && token_i.ready;

  assign token_i.ready = !tok_valid_q || advance;

  always_comb begin
    tok_valid_d = tok_valid_q;
    if (tok_take) begin
      tok_valid_d = 1'b1;
    end else if (advance) begin
      tok_valid_d = 1'b0;
    end
  end

  always_comb begin
    res_valid_d = res_valid_q;
    if (advance) begin
      res_valid_d = 1'b1;
    end else if (result_o.ready) begin
      res_valid_d = 1'b0;
    end
  end

  // parser state and the per-token decision
  kvsp_core #(
    .BufferBytes(BufferBytes)
  ) u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_en_i(advance),
    .tok_i    (tok_q),
    .res_o    (res_next)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok_valid_q <= 1'b0;
      res_valid_q <= 1'b0;
    end else begin
      tok_valid_q <= tok_valid_d;
      res_valid_q <= res_valid_d;
    end
  end

  // payload registers, no reset needed
  always_ff @(posedge clk_i) begin
    if (tok_take) begin
      tok_q <= token_i.data;
    end
    if (advance) begin
      res_q <= res_next;
    end
  end

  assign result_o.valid = res_valid_q;
  assign result_o.data  = res_q;

endmodule

@@ rtl/core/kvsp_core.sv @@
module kvsp_core #(
  parameter int unsigned BufferBytes = kvsp_pkg::BufferBytesDflt
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                step_en_i,
  input  kvsp_pkg::kvsp_tok_t tok_i,
  output kvsp_pkg::kvsp_res_t res_o
);
  import kvsp_pkg::*;

  // highest start offset a quoted string may report
  localparam logic [PosW-1:0] StartLimit =
    ((BufferBytes - 1) > ((1 << PosW) - 1)) ? {PosW{1'b1}} : PosW'(BufferBytes - 1);

  kvsp_phase_e      phase_q, phase_d;
  logic [PosW-1:0]  origin_q, origin_d;
  logic [PosW-1:0]  key_start_q, key_start_d;
  logic [PosW-1:0]  key_len_q, key_len_d;
  logic [PosW-1:0]  val_start_q, val_start_d;
  logic [PosW-1:0]  val_len_q, val_len_d;
  logic [1:0]       have_q, have_d;
  logic [LineW-1:0] line_q, line_d;
  kvsp_err_e        err_q, err_d;
  logic             warn_q, warn_d;
  logic [PosW-1:0]  err_col_q, err_col_d;
  logic [PosW-1:0]  warn_col_q, warn_col_d;
  logic             halted_q, halted_d;

  logic             closed;
  logic             eof;
  kvsp_err_e        err_new;
  logic [PosW-1:0]  col;
  logic [PosW-1:0]  str_start;
  logic [PosW-1:0]  str_len;

  always_comb begin
    phase_d     = phase_q;
    origin_d    = origin_q;
    key_start_d = key_start_q;
    key_len_d   = key_len_q;
    val_start_d = val_start_q;
    val_len_d   = val_len_q;
    have_d      = have_q;
    line_d      = line_q;
    err_d       = err_q;
    warn_d      = warn_q;
    err_col_d   = err_col_q;
    warn_col_d  = warn_col_q;
    halted_d    = halted_q;
    closed      = 1'b0;
    eof         = 1'b0;
    err_new     = ERR_NONE;
    col         = '0;
    str_start   = tok_i.token_position;
    str_len     = tok_i.token_length;

    if (kvsp_tok_e'(tok_i.token_kind) == TOK_QUOTED) begin
      str_start = (tok_i.token_position >= StartLimit) ? StartLimit
                                                       : tok_i.token_position + 12'd1;
      str_len   = (tok_i.token_length >= QuoteTrim) ? tok_i.token_length - QuoteTrim
                                                    : '0;
    end

    if (!halted_q) begin
      // a closed statement: this token opens the next one
      if (phase_q == PH_END) begin
        phase_d     = PH_KEY;
        origin_d    = tok_i.token_position;
        key_start_d = '0;
        key_len_d   = '0;
        val_start_d = '0;
        val_len_d   = '0;
        have_d      = '0;
        warn_d      = 1'b0;
        warn_col_d  = '0;
      end
      col = tok_i.token_position - origin_d;

      unique case (kvsp_tok_e'(tok_i.token_kind))
        TOK_ILLEGAL: err_new = ERR_ILLEGAL;
        TOK_NEWLINE, TOK_RETURN: begin
          if (kvsp_tok_e'(tok_i.token_kind) == TOK_NEWLINE && line_q != {LineW{1'b1}}) begin
            line_d = line_q + 16'd1;
          end
          if (phase_d == PH_ASSIGN || phase_d == PH_VALUE) begin
            err_new = ERR_NEWLINE;
          end else if (phase_d == PH_TRAIL) begin
            closed = 1'b1;
          end
        end
        TOK_COMMENT: begin
          if (phase_d == PH_ASSIGN || phase_d == PH_VALUE) begin
            err_new = ERR_COMMENT;
          end else begin
            closed = 1'b1;
            eof    = tok_i.comment_hits_end;
          end
        end
        TOK_ASSIGN: begin
          if (phase_d == PH_ASSIGN) begin
            phase_d = PH_VALUE;
          end else begin
            err_new = ERR_OPERATOR;
          end
        end
        TOK_QUOTED, TOK_RAW: begin
          if (phase_d == PH_KEY) begin
            key_start_d = str_start;
            key_len_d   = str_len;
            have_d[0]   = 1'b1;
            phase_d     = PH_ASSIGN;
          end else if (phase_d == PH_ASSIGN) begin
            err_new = ERR_STRING;
          end else if (phase_d == PH_VALUE) begin
            val_start_d = str_start;
            val_len_d   = str_len;
            have_d[1]   = 1'b1;
            phase_d     = PH_TRAIL;
          end else if (!warn_d) begin
            warn_d     = 1'b1;
            warn_col_d = col;
          end
        end
        TOK_END: begin
          closed = 1'b1;
          eof    = 1'b1;
        end
        default: ;
      endcase

      if (err_new != ERR_NONE) begin
        closed    = 1'b1;
        err_d     = err_new;
        err_col_d = col;
        halted_d  = 1'b1;
      end
      if (eof) begin
        halted_d = 1'b1;
      end
      if (closed) begin
        phase_d = PH_END;
      end
    end
  end

  always_comb begin
    res_o.statement_done = closed;
    res_o.pair_ready     = closed && (have_d == 2'b11);
    res_o.key_start      = key_start_d;
    res_o.key_size       = key_len_d;
    res_o.value_start    = val_start_d;
    res_o.value_size     = val_len_d;
    res_o.error_code     = err_d;
    res_o.warning_code   = warn_d;
    res_o.error_column   = err_col_d;
    res_o.warning_column = warn_col_d;
    res_o.line_number    = line_d;
    res_o.end_of_input   = halted_d && (err_d == ERR_NONE);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_KEY;
      origin_q    <= '0;
      key_start_q <= '0;
      key_len_q   <= '0;
      val_start_q <= '0;
      val_len_q   <= '0;
      have_q      <= '0;
      line_q      <= '0;
      err_q       <= ERR_NONE;
      warn_q      <= 1'b0;
      err_col_q   <= '0;
      warn_col_q  <= '0;
      halted_q    <= 1'b0;
    end else if (step_en_i) begin
      phase_q     <= phase_d;
      origin_q    <= origin_d;
      key_start_q <= key_start_d;
      key_len_q   <= key_len_d;
      val_start_q <= val_start_d;
      val_len_q   <= val_len_d;
      have_q      <= have_d;
      line_q      <= line_d;
      err_q       <= err_d;
      warn_q      <= warn_d;
      err_col_q   <= err_col_d;
      warn_col_q  <= warn_col_d;
      halted_q    <= halted_d;
    end
  end

  // once halted, only reset leaves that state
  assert property (@(posedge clk_i) disable iff (!rst_ni) halted_q |=> halted_q)
    else $error("halt released without reset");

  // the first error is kept for the rest of the run
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   (err_q != ERR_NONE) |=> $stable(err_q))
    else $error("recorded error changed");

  // an error always halts
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   (err_q != ERR_NONE) |-> halted_q)
    else $error("error recorded without halt");

  // a closed statement moves the parser to the end phase
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   (step_en_i && closed) |=> (phase_q == PH_END))
    else $error("statement closed but phase not at end");

  // the line count never goes backwards
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   1'b1 |=> (line_q >= $past(line_q)))
    else $error("line count decreased");

endmodule

@@ tb/sv/key_value_statement_parser_tb.sv @@
module key_value_statement_parser_tb;
  import kvsp_pkg::*;

  localparam int unsigned BufBytes    = BufferBytesDflt;
  localparam int unsigned RandomItems = 800;
  localparam int unsigned QuietLimit  = 2000;
  localparam int unsigned DrainCycles = 8;
  // a quoted span starts one byte in, never past the last buffer byte
  localparam logic [PosW-1:0] StartLimit =
      (BufBytes - 1 > 4095) ? 12'hFFF : PosW'(BufBytes - 1);

  typedef struct {
    kvsp_tok_t tok;
    bit        pinned;
    kvsp_res_t want;
  } stim_row_t;

  typedef struct {
    bit        pinned;
    kvsp_res_t want;
  } pin_t;

  logic clk;
  logic rst_n;

  kvsp_tok_if tok_if ();
  kvsp_res_if res_if ();

  key_value_statement_parser dut (
    .clk_i   (clk),
    .rst_ni  (rst_n),
    .token_i (tok_if),
    .result_o(res_if)
  );

  // statement tracker, starts in its reset state
  kvsp_phase_e     parse_phase   = PH_KEY;
  logic [PosW-1:0] stmt_origin   = '0;
  logic [PosW-1:0] key_from      = '0;
  logic [PosW-1:0] key_len       = '0;
  logic [PosW-1:0] val_from      = '0;
  logic [PosW-1:0] val_len       = '0;
  logic [1:0]      have_kv       = '0;
  logic [LineW-1:0] line_total   = '0;
  kvsp_err_e       err_held      = ERR_NONE;
  logic            warn_held     = 1'b0;
  logic [PosW-1:0] err_col_held  = '0;
  logic [PosW-1:0] warn_col_held = '0;
  logic            parser_halted = 1'b0;

  kvsp_res_t expected_q [$];
  pin_t      pin_q [$];
  stim_row_t script [25];

  int unsigned     mismatches    = 0;
  int unsigned     sent_items    = 0;
  int unsigned     quiet_cycles  = 0;
  int unsigned     tokens_seen   = 0;
  int unsigned     closed_seen   = 0;
  int unsigned     pairs_seen    = 0;
  int unsigned     warned_seen   = 0;
  int unsigned     src_idle_pct  = 33;
  int unsigned     sink_idle_pct = 53;
  logic [PosW-1:0] buf_cursor    = '0;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // works out the result of one token and moves the tracker on
  function automatic kvsp_res_t parse_token(kvsp_tok_t t);
    kvsp_res_t       r;
    logic            closed;
    logic            eof;
    kvsp_err_e       err;
    logic [PosW-1:0] col;
    logic [PosW-1:0] span_s;
    logic [PosW-1:0] span_l;
    closed = 1'b0;
    eof    = 1'b0;
    err    = ERR_NONE;
    if (!parser_halted) begin
      // first token after a closed statement opens the next one
      if (parse_phase == PH_END) begin
        parse_phase   = PH_KEY;
        stmt_origin   = t.token_position;
        key_from      = '0;
        key_len       = '0;
        val_from      = '0;
        val_len       = '0;
        have_kv       = '0;
        warn_held     = 1'b0;
        warn_col_held = '0;
      end
      col = t.token_position - stmt_origin;
      case (t.token_kind)
        TOK_ILLEGAL: err = ERR_ILLEGAL;
        TOK_NEWLINE, TOK_RETURN: begin
          if (t.token_kind == TOK_NEWLINE && line_total != '1) line_total = line_total + 16'd1;
          if (parse_phase == PH_ASSIGN || parse_phase == PH_VALUE) err = ERR_NEWLINE;
          else if (parse_phase == PH_TRAIL) closed = 1'b1;
        end
        TOK_COMMENT: begin
          if (parse_phase == PH_ASSIGN || parse_phase == PH_VALUE) begin
            err = ERR_COMMENT;
          end else begin
            closed = 1'b1;
            eof    = t.comment_hits_end;
          end
        end
        TOK_ASSIGN: begin
          if (parse_phase == PH_ASSIGN) parse_phase = PH_VALUE;
          else err = ERR_OPERATOR;
        end
        TOK_QUOTED, TOK_RAW: begin
          span_s = t.token_position;
          span_l = t.token_length;
          if (t.token_kind == TOK_QUOTED) begin
            span_s = ({1'b0, t.token_position} + 13'd1 > {1'b0, StartLimit}) ?
                     StartLimit : t.token_position + 12'd1;
            span_l = (t.token_length >= QuoteTrim) ? t.token_length - QuoteTrim : '0;
          end
          if (parse_phase == PH_KEY) begin
            key_from    = span_s;
            key_len     = span_l;
            have_kv[0]  = 1'b1;
            parse_phase = PH_ASSIGN;
          end else if (parse_phase == PH_ASSIGN) begin
            err = ERR_STRING;
          end else if (parse_phase == PH_VALUE) begin
            val_from    = span_s;
            val_len     = span_l;
            have_kv[1]  = 1'b1;
            parse_phase = PH_TRAIL;
          end else if (!warn_held) begin
            // only the first stray string of a statement is kept
            warn_held     = 1'b1;
            warn_col_held = col;
          end
        end
        TOK_END: begin
          closed = 1'b1;
          eof    = 1'b1;
        end
        default: ;
      endcase
      if (err != ERR_NONE) begin
        closed        = 1'b1;
        err_held      = err;
        err_col_held  = col;
        parser_halted = 1'b1;
      end
      if (eof) parser_halted = 1'b1;
      if (closed) parse_phase = PH_END;
    end
    r.statement_done = closed;
    r.pair_ready     = closed && have_kv == 2'b11;
    r.key_start      = key_from;
    r.key_size       = key_len;
    r.value_start    = val_from;
    r.value_size     = val_len;
    r.error_code     = err_held;
    r.warning_code   = warn_held;
    r.error_column   = err_col_held;
    r.warning_column = warn_col_held;
    r.line_number    = line_total;
    r.end_of_input   = parser_halted && err_held == ERR_NONE;
    return r;
  endfunction

  task automatic check_field(string name, logic [15:0] want, logic [15:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      mismatches++;
    end
  endtask

  task automatic compare_result(kvsp_res_t want, kvsp_res_t got);
    check_field("statement_done", 16'(want.statement_done), 16'(got.statement_done));
    check_field("pair_ready", 16'(want.pair_ready), 16'(got.pair_ready));
    check_field("key_start", 16'(want.key_start), 16'(got.key_start));
    check_field("key_size", 16'(want.key_size), 16'(got.key_size));
    check_field("value_start", 16'(want.value_start), 16'(got.value_start));
    check_field("value_size", 16'(want.value_size), 16'(got.value_size));
    check_field("error_code", 16'(want.error_code), 16'(got.error_code));
    check_field("warning_code", 16'(want.warning_code), 16'(got.warning_code));
    check_field("error_column", 16'(want.error_column), 16'(got.error_column));
    check_field("warning_column", 16'(want.warning_column), 16'(got.warning_column));
    check_field("line_number", want.line_number, got.line_number);
    check_field("end_of_input", 16'(want.end_of_input), 16'(got.end_of_input));
    if (want.statement_done) closed_seen++;
    if (want.pair_ready) pairs_seen++;
    if (want.statement_done && want.warning_code) warned_seen++;
  endtask

  // both channels are sampled at the edge, before any driven update lands
  always @(posedge clk) begin : watch_channels
    kvsp_res_t next_res;
    pin_t      pin;
    if (rst_n) begin
      if (tok_if.valid && tok_if.ready) begin
        next_res = parse_token(tok_if.data);
        pin      = pin_q.pop_front();
        expected_q.push_back(pin.pinned ? pin.want : next_res);
        tokens_seen++;
      end
      if (res_if.valid && res_if.ready) begin
        if (expected_q.size() == 0) begin
          $display("%0t: result with nothing expected, expected none, actual %p",
                   $time, res_if.data);
          mismatches++;
        end else begin
          compare_result(expected_q.pop_front(), res_if.data);
        end
      end
      if ((tok_if.valid && tok_if.ready) || (res_if.valid && res_if.ready)) quiet_cycles = 0;
      else quiet_cycles++;
    end
  end

  // result side back-pressure
  always @(posedge clk) begin
    if (!rst_n) res_if.ready <= 1'b0;
    else res_if.ready <= ($urandom_range(99) >= sink_idle_pct);
  end

  initial begin
    wait (rst_n === 1'b1);
    while (quiet_cycles < QuietLimit) @(posedge clk);
    $display("%0t: no transaction for %0d cycles", $time, QuietLimit);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // offers one token, with random idle cycles first, and returns at the
  // edge where the transaction happens
  task automatic send_token(kvsp_tok_t t, bit pinned = 1'b0, kvsp_res_t want = '0);
    pin_q.push_back('{pinned, want});
    sent_items++;
    while ($urandom_range(99) < src_idle_pct) begin
      tok_if.valid <= 1'b0;
      @(posedge clk);
    end
    tok_if.valid <= 1'b1;
    tok_if.data  <= t;
    do @(posedge clk); while (!tok_if.ready);
  endtask

  // mostly follows on from the last token in the buffer, sometimes jumps
  function automatic kvsp_tok_t text_token(logic [3:0] kind);
    kvsp_tok_t   t;
    int unsigned pick;
    t.token_kind = kind;
    pick = $urandom_range(99);
    if (pick < 40) t.token_length = PosW'($urandom_range(0, 3));
    else if (pick < 80) t.token_length = PosW'($urandom_range(1, 40));
    else t.token_length = PosW'($urandom);
    if ($urandom_range(9) < 7) t.token_position = buf_cursor;
    else t.token_position = PosW'($urandom);
    buf_cursor = t.token_position + t.token_length + 12'd1;
    t.comment_hits_end = (kind == TOK_COMMENT) ? 1'b0 : 1'($urandom);
    return t;
  endfunction

  // spaces and unknown token codes, which the parser passes over
  task automatic send_noise();
    logic [3:0] kind;
    if ($urandom_range(3) == 0) begin
      repeat ($urandom_range(1, 2)) begin
        kind = 4'($urandom_range(8, 15));
        if (kind == TOK_END) kind = TOK_SPACE;
        send_token(text_token(kind));
      end
    end
  endtask

  task automatic send_statement();
    if ($urandom_range(99) < 10) begin
      // blank lines then a comment line, nothing captured
      repeat ($urandom_range(0, 2)) send_token(text_token($urandom_range(1) ? TOK_NEWLINE : TOK_RETURN));
      send_token(text_token(TOK_COMMENT));
    end else begin
      send_noise();
      send_token(text_token($urandom_range(1) ? TOK_QUOTED : TOK_RAW));
      send_noise();
      send_token(text_token(TOK_ASSIGN));
      send_noise();
      send_token(text_token($urandom_range(1) ? TOK_QUOTED : TOK_RAW));
      // stray strings after the value raise the warning
      if ($urandom_range(3) == 0) begin
        repeat ($urandom_range(1, 2)) begin
          send_noise();
          send_token(text_token($urandom_range(1) ? TOK_QUOTED : TOK_RAW));
        end
      end
      send_noise();
      case ($urandom_range(2))
        0:       send_token(text_token(TOK_NEWLINE));
        1:       send_token(text_token(TOK_RETURN));
        default: send_token(text_token(TOK_COMMENT));
      endcase
    end
  endtask

  // ends the run with one error or end of input, reached from a random
  // point in a statement, then checks that the halted parser holds still
  task automatic send_breakdown();
    int unsigned depth;
    logic [3:0]  menu [$];
    kvsp_tok_t   t;
    depth = $urandom_range(0, 3);
    if (depth >= 1) send_token(text_token($urandom_range(1) ? TOK_QUOTED : TOK_RAW));
    if (depth >= 2) send_token(text_token(TOK_ASSIGN));
    if (depth == 3) send_token(text_token($urandom_range(1) ? TOK_QUOTED : TOK_RAW));
    case (depth)
      0, 3:    menu = '{TOK_ILLEGAL, TOK_ASSIGN, TOK_END, TOK_COMMENT};
      1:       menu = '{TOK_ILLEGAL, TOK_NEWLINE, TOK_RETURN, TOK_COMMENT,
                        TOK_QUOTED, TOK_RAW, TOK_END};
      default: menu = '{TOK_ILLEGAL, TOK_NEWLINE, TOK_RETURN, TOK_COMMENT,
                        TOK_ASSIGN, TOK_END};
    endcase
    t = text_token(menu[$urandom_range(menu.size() - 1)]);
    // outside a statement only a comment that runs into the end halts
    if (t.token_kind == TOK_COMMENT) t.comment_hits_end = (depth == 0 || depth == 3) ? 1'b1 : 1'($urandom);
    send_token(t);
    repeat (8) begin
      t = '{4'($urandom), PosW'($urandom), PosW'($urandom), 1'($urandom)};
      send_token(t);
    end
  endtask

  initial begin
    string       halted_by;
    int unsigned progress;
    rst_n        = 1'b0;
    tok_if.valid = 1'b0;
    tok_if.data  = '0;
    // type, position, length, comment reaches end; pinned; held result
    script = '{
      // after reset everything reads zero, a space changes nothing
      '{'{TOK_SPACE, 12'd5, 12'd1, 1'b0}, 1'b1,
        '{1'b0, 1'b0, 12'd0, 12'd0, 12'd0, 12'd0, ERR_NONE, 1'b0, 12'd0, 12'd0, 16'd0, 1'b0}},
      // newline and return while waiting for a key, only the newline counts
      '{'{TOK_NEWLINE, 12'd0, 12'd1, 1'b0}, 1'b1,
        '{1'b0, 1'b0, 12'd0, 12'd0, 12'd0, 12'd0, ERR_NONE, 1'b0, 12'd0, 12'd0, 16'd1, 1'b0}},
      '{'{TOK_RETURN, 12'd1, 12'd1, 1'b0}, 1'b1,
        '{1'b0, 1'b0, 12'd0, 12'd0, 12'd0, 12'd0, ERR_NONE, 1'b0, 12'd0, 12'd0, 16'd1, 1'b0}},
      // quoted key at the last byte, start saturates
      '{'{TOK_QUOTED, 12'd4095, 12'd4095, 1'b1}, 1'b1,
        '{1'b0, 1'b0, 12'd4095, 12'd4093, 12'd0, 12'd0, ERR_NONE, 1'b0, 12'd0, 12'd0, 16'd1,
          1'b0}},
      '{'{TOK_ASSIGN, 12'd10, 12'd1, 1'b0}, 1'b0, '0},
      // one-byte quoted value trims to nothing
      '{'{TOK_QUOTED, 12'd20, 12'd1, 1'b0}, 1'b0, '0},
      // two stray strings, the first one's column is kept
      '{'{TOK_RAW, 12'd30, 12'd5, 1'b1}, 1'b0, '0},
      '{'{TOK_RAW, 12'd40, 12'd5, 1'b0}, 1'b0, '0},
      '{'{TOK_NEWLINE, 12'd50, 12'd1, 1'b0}, 1'b1,
        '{1'b1, 1'b1, 12'd4095, 12'd4093, 12'd21, 12'd0, ERR_NONE, 1'b1, 12'd0, 12'd30,
          16'd2, 1'b0}},
      // empty quoted key opens a new statement
      '{'{TOK_QUOTED, 12'd100, 12'd0, 1'b0}, 1'b0, '0},
      '{'{4'd15, 12'd4095, 12'd4095, 1'b1}, 1'b0, '0},
      '{'{TOK_ASSIGN, 12'd102, 12'd1, 1'b0}, 1'b0, '0},
      '{'{TOK_RAW, 12'd103, 12'd4095, 1'b1}, 1'b0, '0},
      '{'{TOK_QUOTED, 12'd4000, 12'd2, 1'b0}, 1'b0, '0},
      '{'{TOK_COMMENT, 12'd4090, 12'd6, 1'b0}, 1'b0, '0},
      // comment on a line of its own closes an empty statement
      '{'{TOK_COMMENT, 12'd0, 12'd3, 1'b0}, 1'b0, '0},
      '{'{TOK_RAW, 12'd4095, 12'd0, 1'b0}, 1'b0, '0},
      '{'{TOK_ASSIGN, 12'd5, 12'd1, 1'b1}, 1'b0, '0},
      '{'{TOK_QUOTED, 12'd4094, 12'd3, 1'b0}, 1'b0, '0},
      // column wraps round the end of the buffer
      '{'{TOK_RAW, 12'd3, 12'd1, 1'b0}, 1'b0, '0},
      '{'{TOK_RETURN, 12'd7, 12'd1, 1'b1}, 1'b0, '0},
      '{'{TOK_QUOTED, 12'd0, 12'd4095, 1'b1}, 1'b0, '0},
      '{'{TOK_ASSIGN, 12'd4095, 12'd0, 1'b0}, 1'b0, '0},
      '{'{TOK_RAW, 12'hAAA, 12'h555, 1'b0}, 1'b0, '0},
      '{'{TOK_NEWLINE, 12'h555, 12'hAAA, 1'b1}, 1'b0, '0}
    };
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (script[i]) send_token(script[i].tok, script[i].pinned, script[i].want);

    // random statements, idling swapped between the sides after a third, then none
    while (sent_items < $size(script) + RandomItems) begin
      progress = sent_items - $size(script);
      if (progress < RandomItems / 3) begin
        src_idle_pct  = 33;
        sink_idle_pct = 53;
      end else if (progress < 2 * RandomItems / 3) begin
        src_idle_pct  = 53;
        sink_idle_pct = 33;
      end else begin
        src_idle_pct  = 0;
        sink_idle_pct = 0;
      end
      send_statement();
    end

    send_breakdown();
    tok_if.valid <= 1'b0;
    @(posedge clk);
    while (expected_q.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);

    halted_by = (err_held == ERR_NONE) ? "end of input" : err_held.name();
    $display("%0d tokens in, %0d statements closed, %0d with a pair, %0d with a warning",
             tokens_seen, closed_seen, pairs_seen, warned_seen);
    $display("line count ended at %0d, parser halted by %s", line_total, halted_by);
    if (mismatches == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

@@ sim.f @@
rtl/core/kvsp_pkg.sv
rtl/core/kvsp_if.sv
rtl/core/kvsp_core.sv
rtl/core/key_value_statement_parser.sv
tb/sv/key_value_statement_parser_tb.sv
